>>> src/assert_macros.svh
// Assertion macros for the RTL core.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that an expression never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> src/sfcs_pkg.sv
// Package for the sensor frame check and scale core: widths, scaling constants,
// status codes and the CRC-8 byte function. No dependencies.
package sfcs_pkg;

	localparam int InDataW  = 24;
	localparam int OutDataW = 24;
	localparam int OutUserW = 3;
	localparam int ValueW   = 18;
	localparam int RawW     = 16;
	localparam int GainW    = 18;
	localparam int ProdW    = RawW + GainW;
	localparam int NumW     = ProdW + 1;
	localparam int FracW    = 16;

	localparam logic [7:0]        CRC_POLY  = 8'h31;
	localparam logic [RawW-1:0]   MASK_TEMP = 16'hfffb;
	localparam logic [RawW-1:0]   MASK_HUM  = 16'hfff0;
	localparam logic [GainW-1:0]  TEMP_GAIN = 18'd175720;
	localparam logic [GainW-1:0]  HUM_GAIN  = 18'd125000;
	// offsets already scaled by 2^16
	localparam logic [NumW-1:0]   TEMP_OFFS = 35'd3070361600;
	localparam logic [NumW-1:0]   HUM_OFFS  = 35'd393216000;
	localparam logic [ValueW-1:0] RANGE_MAX = 18'd100000;

	localparam logic KIND_TEMP = 1'b0;
	localparam logic KIND_HUM  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_REJECT = 2'd1,
		STATUS_RANGE  = 2'd2
	} status_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> src/sensor_frame_check_and_scale_core.sv
// Usage: one sensor frame enters on the s_axis channel, one result leaves on
// the m_axis channel for every frame, in order.
//   s_axis_tdata : high_byte [7:0], low_byte [15:8], check_byte [23:16]
//   s_axis_tuser : kind (0 temperature, 1 relative humidity)
//   m_axis_tdata : value_milli [17:0] (signed thousandths), zero pad [23:18]
//   m_axis_tuser : status [1:0], reset_request [2]
// The frame is checked with CRC-8 (poly 0x31, init 0) over the two data bytes;
// a mismatch or an all-zero frame gives status 1 and value 0. Otherwise the
// masked raw word is scaled with one 16x18 constant multiply; a value outside
// 0..100000 gives -1, status 2 and a sensor reset request.
// The input register loads at the input transfer; the result register loads from
// it whenever it is empty or being read. Throughput: one frame per cycle unless the
// receiver stalls, set by the single multiply and CRC between the two registers.
// While the receiver stalls, the result register holds and the input
// register still takes one more frame; ready drops only when both are full.
// Reset empties both stages; no results are pending afterwards.
// Depends on sfcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sensor_frame_check_and_scale_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// high_byte [7:0], low_byte [15:8], check_byte [23:16]
	input  logic [sfcs_pkg::InDataW-1:0]  s_axis_tdata,
	// kind [0]
	input  logic [0:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// value_milli [17:0], zero pad [23:18]
	output logic [sfcs_pkg::OutDataW-1:0] m_axis_tdata,
	// status [1:0], reset_request [2]
	output logic [sfcs_pkg::OutUserW-1:0] m_axis_tuser
);
	import sfcs_pkg::*;

	logic                valid_s1;
	logic                kind_s1;
	logic [7:0]          hi_s1;
	logic [7:0]          lo_s1;
	logic [7:0]          chk_s1;

	logic                valid_s2;
	logic [ValueW-1:0]   value_s2;
	status_t             status_s2;
	logic                rreq_s2;

	logic                load_s2;
	logic                load_s1;

	logic [7:0]          crc;
	logic                reject;
	logic [RawW-1:0]     raw;
	logic [GainW-1:0]    gain;
	logic [NumW-1:0]     offs;
	logic [ProdW-1:0]    prod;
	logic [NumW-1:0]     num;
	logic [ValueW-1:0]   quot;
	logic [ValueW-1:0]   value_d;
	status_t             status_d;

	assign load_s2       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || load_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1 <= s_axis_tuser[0];
			hi_s1   <= s_axis_tdata[7:0];
			lo_s1   <= s_axis_tdata[15:8];
			chk_s1  <= s_axis_tdata[23:16];
		end
	end

	always_comb begin
		crc    = crc8_byte(crc8_byte(8'h00, hi_s1), lo_s1);
		reject = (crc != chk_s1) || ((hi_s1 == 8'h00) && (lo_s1 == 8'h00) && (chk_s1 == 8'h00));
		if (kind_s1 == KIND_TEMP) begin
			raw  = {hi_s1, lo_s1} & MASK_TEMP;
			gain = TEMP_GAIN;
			offs = TEMP_OFFS;
		end else begin
			raw  = {hi_s1, lo_s1} & MASK_HUM;
			gain = HUM_GAIN;
			offs = HUM_OFFS;
		end
		prod = ProdW'(raw) * ProdW'(gain);
		num  = {1'b0, prod} - offs;
		quot = num[FracW +: ValueW];

		value_d  = '0;
		status_d = STATUS_OK;
		if (reject) begin
			status_d = STATUS_REJECT;
		end else if (!num[NumW-1]) begin
			if (quot > RANGE_MAX) begin
				value_d  = '1;
				status_d = STATUS_RANGE;
			end else begin
				value_d = quot;
			end
		end else if (!((&num[NumW-1:FracW]) && (num[FracW-1:0] != '0))) begin
			// negative beyond what truncation toward zero brings back to 0
			value_d  = '1;
			status_d = STATUS_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			value_s2  <= value_d;
			status_s2 <= status_d;
			rreq_s2   <= (status_d == STATUS_RANGE);
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(OutDataW - ValueW)'(0), value_s2};
	assign m_axis_tuser  = {rreq_s2, status_s2};

	`ASSERT_CLK(a_range_result, clk, arst_n,
		(m_axis_tvalid && status_s2 == STATUS_RANGE) |-> (rreq_s2 && (&value_s2)))
	`ASSERT_CLK(a_ok_in_range, clk, arst_n,
		(m_axis_tvalid && status_s2 == STATUS_OK) |-> (!rreq_s2 && value_s2 <= RANGE_MAX))
	`ASSERT_CLK(a_advance, clk, arst_n,
		(valid_s1 && load_s2) |=> m_axis_tvalid)
	`ASSERT_NEVER(a_reject_clean, clk, arst_n,
		m_axis_tvalid && status_s2 == STATUS_REJECT && (rreq_s2 || value_s2 != '0))

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for sensor_frame_check_and_scale_core: directed frames from a
// table, then random frames, checked against row values or a CRC-8 and scaling model.
// Depends on sfcs_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
	import sfcs_pkg::*;

	localparam longint TEMP_MUL  = 175720;
	localparam longint TEMP_SUB  = 46850;
	localparam longint HUM_MUL   = 125000;
	localparam longint HUM_SUB   = 6000;
	localparam longint LIMIT_MAX = 100000;
	localparam int     NUM_ROWS  = 23;
	localparam int     NUM_RAND  = 1030;
	localparam int     HOLD_LEN  = 250;

	typedef struct packed {
		logic [ValueW-1:0] value;
		status_t           status;
		logic              rr;
	} reading_t;

	typedef struct packed {
		logic     typed;
		reading_t res;
	} row_exp_t;

	// crc_fix: check byte is the frame CRC xor chk
	typedef struct packed {
		logic       kind;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] chk;
		logic       crc_fix;
		logic       typed;
		reading_t   res;
	} frame_row_t;

	localparam reading_t RD_REJ = '{value: '0, status: STATUS_REJECT, rr: 1'b0};
	localparam reading_t RD_RNG = '{value: 18'h3ffff, status: STATUS_RANGE, rr: 1'b1};
	localparam reading_t RD_ZERO = '{value: '0, status: STATUS_OK, rr: 1'b0};
	localparam reading_t RD_NONE = '{value: '0, status: STATUS_OK, rr: 1'b0};

	frame_row_t dir_rows [NUM_ROWS] = '{
		'{KIND_TEMP, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, RD_REJ},  // all-zero frame
		'{KIND_HUM,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, RD_REJ},
		'{KIND_TEMP, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1, RD_REJ},
		'{KIND_HUM,  8'h12, 8'h34, 8'h01, 1'b1, 1'b1, RD_REJ},  // one check bit off
		'{KIND_TEMP, 8'hff, 8'hff, 8'h80, 1'b1, 1'b1, RD_REJ},
		'{KIND_TEMP, 8'hff, 8'hff, 8'h00, 1'b1, 1'b1, RD_RNG},  // above full scale
		'{KIND_HUM,  8'hff, 8'hff, 8'h00, 1'b1, 1'b1, RD_RNG},
		'{KIND_TEMP, 8'h00, 8'h01, 8'h00, 1'b1, 1'b1, RD_RNG},  // far below zero
		'{KIND_HUM,  8'h00, 8'h0f, 8'h00, 1'b1, 1'b1, RD_RNG},
		'{KIND_TEMP, 8'h44, 8'h41, 8'h00, 1'b1, 1'b1, RD_ZERO}, // truncates to zero
		'{KIND_TEMP, 8'h44, 8'h40, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_HUM,  8'h0c, 8'h40, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_HUM,  8'h0c, 8'h50, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_TEMP, 8'hd5, 8'hf0, 8'h00, 1'b1, 1'b0, RD_NONE}, // near upper limit
		'{KIND_TEMP, 8'hd5, 8'hf1, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_HUM,  8'hd9, 8'h10, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_HUM,  8'hd9, 8'h20, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_TEMP, 8'h60, 8'h04, 8'h00, 1'b1, 1'b0, RD_NONE}, // masked status bit
		'{KIND_HUM,  8'h12, 8'h3f, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_HUM,  8'h80, 8'h00, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_TEMP, 8'haa, 8'h55, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_HUM,  8'h7f, 8'hff, 8'h00, 1'b1, 1'b0, RD_NONE},
		'{KIND_HUM,  8'h00, 8'h00, 8'h01, 1'b0, 1'b1, RD_REJ}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata = '0;
	logic [0:0]          s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic [OutUserW-1:0] m_axis_tuser;

	reading_t reading_q [$];
	row_exp_t typed_q [$];
	int       frames_in = 0;
	int       outstanding = 0;
	int       mismatches = 0;
	int       hold_left = 0;
	logic     hold_done = 1'b0;

	sensor_frame_check_and_scale_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// bit-serial CRC-8, poly 0x31, init 0, high byte first
	function automatic logic [7:0] frame_crc(input logic [7:0] hi, input logic [7:0] lo);
		logic [15:0] word;
		logic [7:0]  crc;
		logic        fb;
		word = {hi, lo};
		crc = 8'h00;
		for (int i = 15; i >= 0; i--) begin
			fb = crc[7] ^ word[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
		end
		return crc;
	endfunction

	function automatic reading_t convert_frame(input logic kind, input logic [7:0] hi,
			input logic [7:0] lo, input logic [7:0] chk);
		reading_t r;
		longint   raw_m;
		longint   num;
		longint   q;
		if (frame_crc(hi, lo) != chk || {hi, lo, chk} == 24'h0)
			return RD_REJ;
		raw_m = longint'({hi, lo});
		if (kind == KIND_TEMP) begin
			raw_m = raw_m & 64'hfffb;
			num = TEMP_MUL * raw_m - TEMP_SUB * 65536;
		end else begin
			raw_m = raw_m & 64'hfff0;
			num = HUM_MUL * raw_m - HUM_SUB * 65536;
		end
		// truncate toward zero
		q = (num >= 0) ? (num >>> 16) : -((-num) >>> 16);
		if (q < 0 || q > LIMIT_MAX)
			return RD_RNG;
		r.value = q[ValueW-1:0];
		r.status = STATUS_OK;
		r.rr = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int sender_idle_pct(input int n);
		if (n < 350)
			return 35;
		else if (n < 700)
			return 77;
		return 0;
	endfunction

	function automatic int receiver_idle_pct(input int n);
		if (n < 350)
			return 77;
		else if (n < 700)
			return 35;
		return 0;
	endfunction

	// Receiver: random stalls, plus one long hold-off to back up the pipeline
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && frames_in >= 300) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct(frames_in));
		end
	end

	// Predict on each input transfer, check each output transfer
	always @(posedge clk) begin : monitor
		logic     in_acc;
		logic     out_acc;
		row_exp_t ov;
		reading_t want;
		if (arst_n) begin
			in_acc = s_axis_tvalid && s_axis_tready;
			out_acc = m_axis_tvalid && m_axis_tready;
			if (in_acc) begin
				ov = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
				if (ov.typed)
					reading_q.push_back(ov.res);
				else
					reading_q.push_back(convert_frame(s_axis_tuser[0], s_axis_tdata[7:0],
						s_axis_tdata[15:8], s_axis_tdata[23:16]));
				frames_in <= frames_in + 1;
			end
			if (out_acc) begin
				if (reading_q.size() == 0) begin
					report_mismatch("unexpected result", 32'(m_axis_tdata), 0);
				end else begin
					want = reading_q.pop_front();
					if (m_axis_tdata[ValueW-1:0] !== want.value)
						report_mismatch("value_milli", 32'(m_axis_tdata[ValueW-1:0]),
							32'(want.value));
					if (m_axis_tdata[OutDataW-1:ValueW] !== '0)
						report_mismatch("tdata pad", 32'(m_axis_tdata[OutDataW-1:ValueW]), 0);
					if (m_axis_tuser[1:0] !== want.status)
						report_mismatch("status", 32'(m_axis_tuser[1:0]), 32'(want.status));
					if (m_axis_tuser[2] !== want.rr)
						report_mismatch("reset_request", 32'(m_axis_tuser[2]), 32'(want.rr));
				end
			end
			outstanding <= outstanding + int'(in_acc) - int'(out_acc);
		end
	end

	task automatic send_frame(input logic kind, input logic [7:0] hi, input logic [7:0] lo,
			input logic [7:0] chk, input row_exp_t ov);
		typed_q.push_back(ov);
		while ($urandom_range(99) < sender_idle_pct(frames_in)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {chk, lo, hi};
		s_axis_tuser <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic drain_results();
		do begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end while (outstanding != 0);
	endtask

	initial begin : stimulus
		frame_row_t row;
		row_exp_t   ov;
		logic       kind;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] chk;
		int         pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			chk = row.crc_fix ? (frame_crc(row.hi, row.lo) ^ row.chk) : row.chk;
			ov.typed = row.typed;
			ov.res = row.res;
			send_frame(row.kind, row.hi, row.lo, chk, ov);
		end

		ov = '0;
		for (int n = 0; n < NUM_RAND; n++) begin
			// pause once until every result is back
			if (n == 500)
				drain_results();
			kind = 1'($urandom_range(1));
			hi = 8'($urandom_range(255));
			lo = 8'($urandom_range(255));
			pick = $urandom_range(99);
			if (pick < 72) begin
				chk = frame_crc(hi, lo);
			end else if (pick < 80) begin
				hi = 8'h00;
				lo = 8'h00;
				chk = 8'h00;
			end else if (pick < 92) begin
				chk = frame_crc(hi, lo) ^ (8'h01 << $urandom_range(7));
			end else begin
				chk = 8'($urandom_range(255));
			end
			send_frame(kind, hi, lo, chk, ov);
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && reading_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/sfcs_pkg.sv
src/sensor_frame_check_and_scale_core.sv
tb/tb_top.sv
